// ===== sv/taa_pkg.sv =====
`default_nettype none
package taa_pkg;

  localparam int SIDE_WIDTH    = 16;
  localparam int FRACTION_BITS = 8;

  localparam int AREA_W   = 24;
  localparam int ANGLE_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [AREA_W-1:0]  AREA_MAX  = 24'hFFFFFF;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;

  // normalized cosine terms sit in [2^(NORM_BITS-1), 2^NORM_BITS)
  localparam int NORM_BITS    = 30;
  localparam int CORDIC_STEPS = 22;
  localparam int CORDIC_W     = NORM_BITS + 4;
  localparam int Z_W          = 25;
  localparam int PHI_W        = 24;
  localparam logic [PHI_W-1:0] PHI_MAX   = 24'd5898240;   // 90 deg * 2^16
  localparam logic [PHI_W-1:0] HALF_TURN = 24'd11796480;  // 180 deg * 2^16

  // angle path: six front stages, square root, CORDIC, output stage
  localparam int ANGLE_LAT = 6 + NORM_BITS + CORDIC_STEPS + 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NEG   = 2'd2,
    ST_NOTRI = 2'd3
  } status_t;

  // f terms, three multiplies, square root of 4*(sw+1) bits, output stage
  function automatic int area_lat(input int sw);
    return 5 + 2 * (sw + 1);
  endfunction

  // atan(2^-i) in degrees * 2^16
  function automatic int atan_deg(input int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      default: return 0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== sv/triangle_area_and_angles_core.sv =====
`default_nettype none
// Triangle area (Heron) and the three angles (law of cosines) from three signed
// side lengths. One word in per clock while in_ready is high, one result word
// out per input word, in order. The longer of the two paths sets the depth: the
// angle path (normalization, a 30-stage square root and 22 CORDIC stages) at
// the default width, the area square root at wide sides. The whole pipeline
// advances together; a two-entry output buffer lets results back up, and
// in_ready drops only once both entries are full.
// Errors (zero side, negative side, no triangle) give zero area and angles.
module triangle_area_and_angles_core #(
  parameter int SIDE_WIDTH    = taa_pkg::SIDE_WIDTH,
  parameter int FRACTION_BITS = taa_pkg::FRACTION_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SIDE_WIDTH-1:0]   in_side_a,
  input  wire logic signed [SIDE_WIDTH-1:0]   in_side_b,
  input  wire logic signed [SIDE_WIDTH-1:0]   in_side_c,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [taa_pkg::STATUS_W-1:0]        out_status,
  output logic [taa_pkg::AREA_W-1:0]          out_area,
  output logic [taa_pkg::ANGLE_W-1:0]         out_angle_a,
  output logic [taa_pkg::ANGLE_W-1:0]         out_angle_b,
  output logic [taa_pkg::ANGLE_W-1:0]         out_angle_c
);

  localparam int SW     = SIDE_WIDTH;
  localparam int AR_LAT = taa_pkg::area_lat(SW);
  localparam int AN_LAT = taa_pkg::ANGLE_LAT;
  localparam int LAT    = (AR_LAT > AN_LAT) ? AR_LAT : AN_LAT;
  localparam int AGW    = taa_pkg::ANGLE_W;

  typedef struct packed {
    taa_pkg::status_t                status;
    logic [taa_pkg::AREA_W-1:0]      area;
    logic [AGW-1:0]                  ang_a;
    logic [AGW-1:0]                  ang_b;
    logic [AGW-1:0]                  ang_c;
  } res_t;

  logic en;
  logic skid_vld_r, out_vld_r;
  assign en       = !skid_vld_r;
  assign in_ready = en;

  // stage 0: input register
  logic signed [SW-1:0] a0_r, b0_r, c0_r;
  logic [LAT:0]         vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r <= in_side_a;
      b0_r <= in_side_b;
      c0_r <= in_side_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:0], in_valid};
    end
  end

  // checks in priority order
  logic signed [SW:0] sa, sb, sc;
  taa_pkg::status_t   st0;
  assign sa = {a0_r[SW-1], a0_r};
  assign sb = {b0_r[SW-1], b0_r};
  assign sc = {c0_r[SW-1], c0_r};
  always_comb begin
    if (a0_r == '0 || b0_r == '0 || c0_r == '0) begin
      st0 = taa_pkg::ST_ZERO;
    end else if (a0_r < 0 || b0_r < 0 || c0_r < 0) begin
      st0 = taa_pkg::ST_NEG;
    end else if ((sa + sb) < sc || (sb + sc) < sa || (sa + sc) < sb) begin
      st0 = taa_pkg::ST_NOTRI;
    end else begin
      st0 = taa_pkg::ST_OK;
    end
  end

  logic [taa_pkg::STATUS_W-1:0] st_end;
  taa_delay #(.W(taa_pkg::STATUS_W), .D(LAT)) u_dly_st (
    .clk (clk),
    .en  (en),
    .d   (st0),
    .q   (st_end)
  );

  logic [taa_pkg::AREA_W-1:0] area_raw, area_end;
  taa_area #(.SW(SW), .FB(FRACTION_BITS)) u_area (
    .clk  (clk),
    .en   (en),
    .a    (a0_r),
    .b    (b0_r),
    .c    (c0_r),
    .area (area_raw)
  );

  taa_delay #(.W(taa_pkg::AREA_W), .D(LAT - AR_LAT)) u_dly_area (
    .clk (clk),
    .en  (en),
    .d   (area_raw),
    .q   (area_end)
  );

  logic [AGW-1:0] ang_a, ang_b, ang_c;
  logic [3*AGW-1:0] ang_end;

  taa_angle #(.SW(SW)) u_ang_a (
    .clk (clk), .en (en),
    .p (a0_r[SW-2:0]), .q (b0_r[SW-2:0]), .r (c0_r[SW-2:0]),
    .angle (ang_a)
  );
  taa_angle #(.SW(SW)) u_ang_b (
    .clk (clk), .en (en),
    .p (b0_r[SW-2:0]), .q (c0_r[SW-2:0]), .r (a0_r[SW-2:0]),
    .angle (ang_b)
  );
  taa_angle #(.SW(SW)) u_ang_c (
    .clk (clk), .en (en),
    .p (c0_r[SW-2:0]), .q (a0_r[SW-2:0]), .r (b0_r[SW-2:0]),
    .angle (ang_c)
  );

  taa_delay #(.W(3 * AGW), .D(LAT - AN_LAT)) u_dly_ang (
    .clk (clk),
    .en  (en),
    .d   ({ang_a, ang_b, ang_c}),
    .q   (ang_end)
  );

  res_t res;
  logic ok_end;
  assign ok_end = (taa_pkg::status_t'(st_end) == taa_pkg::ST_OK);
  always_comb begin
    res.status = taa_pkg::status_t'(st_end);
    res.area   = ok_end ? area_end : '0;
    res.ang_a  = ok_end ? ang_end[3*AGW-1:2*AGW] : '0;
    res.ang_b  = ok_end ? ang_end[2*AGW-1:AGW] : '0;
    res.ang_c  = ok_end ? ang_end[AGW-1:0] : '0;
  end

  // two-entry output buffer
  res_t out_r, skid_r;
  logic push, pop;
  assign push = en && vld_r[LAT];
  assign pop  = out_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r) begin
        out_vld_r <= push;
      end else if (pop) begin
        if (skid_vld_r) begin
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= push;
        end
      end else if (push) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || pop) begin
      out_r <= skid_vld_r ? skid_r : res;
    end
    if (out_vld_r && !pop && push) begin
      skid_r <= res;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_status  = out_r.status;
  assign out_area    = out_r.area;
  assign out_angle_a = out_r.ang_a;
  assign out_angle_b = out_r.ang_b;
  assign out_angle_c = out_r.ang_c;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without an output word");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status != taa_pkg::ST_OK) |->
      (out_area == '0 && out_angle_a == '0 && out_angle_b == '0 && out_angle_c == '0))
    else $error("error word carries nonzero area or angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_angle_a <= taa_pkg::ANGLE_MAX && out_angle_b <= taa_pkg::ANGLE_MAX
                   && out_angle_c <= taa_pkg::ANGLE_MAX))
    else $error("angle above 180 degrees");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && $past(!en)) |-> $stable(vld_r))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== sv/taa_delay.sv =====
`default_nettype none
module taa_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  if (D == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [W-1:0] tap_r [D];
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[0] <= d;
        for (int i = 1; i < D; i++) begin
          tap_r[i] <= tap_r[i-1];
        end
      end
    end
    assign q = tap_r[D-1];
  end

endmodule
`default_nettype wire

// ===== sv/taa_isqrt.sv =====
`default_nettype none
// floor(sqrt(rad)), one root bit per stage
module taa_isqrt #(
  parameter int N = 60
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [N-1:0]   rad,
  output logic      [N/2-1:0] root
);

  localparam int RB = N / 2;

  logic [RB:0]   rem_r  [RB];
  logic [RB-1:0] root_r [RB];
  logic [N-1:0]  rad_r  [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RB-1:0] rem_in;
    logic [RB-1:0] root_in;
    logic [N-1:0]  rad_in;
    logic [RB+1:0] cur;
    logic [RB+1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1][RB-1:0];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    assign cur   = {rem_in, rad_in[N-1:N-2]};
    assign trial = {root_in, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (RB+1)'(cur - trial) : (RB+1)'(cur);
        root_r[k] <= {root_in[RB-2:0], take};
        rad_r[k]  <= {rad_in[N-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RB-1];

endmodule
`default_nettype wire

// ===== sv/taa_cordic.sv =====
`default_nettype none
// vectoring CORDIC, angle in degrees * 2^16, one micro-rotation per stage
module taa_cordic (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic        [taa_pkg::NORM_BITS-1:0] x_in,
  input  wire logic        [taa_pkg::NORM_BITS-1:0] y_in,
  output logic signed      [taa_pkg::Z_W-1:0]       z_out
);

  localparam int ST = taa_pkg::CORDIC_STEPS;
  localparam int CW = taa_pkg::CORDIC_W;
  localparam int ZW = taa_pkg::Z_W;

  logic signed [CW-1:0] x_r [ST];
  logic signed [CW-1:0] y_r [ST];
  logic signed [ZW-1:0] z_r [ST];

  for (genvar i = 0; i < ST; i++) begin : g_step
    logic signed [CW-1:0] x_in_i;
    logic signed [CW-1:0] y_in_i;
    logic signed [ZW-1:0] z_in_i;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    localparam logic signed [ZW-1:0] ANG = ZW'(taa_pkg::atan_deg(i));

    if (i == 0) begin : g_first
      assign x_in_i = signed'(CW'(x_in));
      assign y_in_i = signed'(CW'(y_in));
      assign z_in_i = '0;
    end else begin : g_next
      assign x_in_i = x_r[i-1];
      assign y_in_i = y_r[i-1];
      assign z_in_i = z_r[i-1];
    end

    assign xs = x_in_i >>> i;
    assign ys = y_in_i >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_in_i > 0) begin
          x_r[i] <= x_in_i + ys;
          y_r[i] <= y_in_i - xs;
          z_r[i] <= z_in_i + ANG;
        end else begin
          x_r[i] <= x_in_i - ys;
          y_r[i] <= y_in_i + xs;
          z_r[i] <= z_in_i - ANG;
        end
      end
    end
  end

  assign z_out = z_r[ST-1];

endmodule
`default_nettype wire

// ===== sv/taa_angle.sv =====
`default_nettype none
// angle opposite p by the law of cosines
module taa_angle #(
  parameter int SW = taa_pkg::SIDE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [SW-2:0]                 p,
  input  wire logic [SW-2:0]                 q,
  input  wire logic [SW-2:0]                 r,
  output logic      [taa_pkg::ANGLE_W-1:0]   angle
);

  localparam int MW  = SW - 1;
  localparam int DW  = 2 * MW + 1;
  localparam int NB  = taa_pkg::NORM_BITS;
  localparam int MSW = $clog2(DW);
  localparam int SHW = DW + NB - 1;
  localparam int ZW  = taa_pkg::Z_W;
  localparam int PW  = taa_pkg::PHI_W;

  logic [2*MW-1:0] pe, qe, re;
  assign pe = {{MW{1'b0}}, p};
  assign qe = {{MW{1'b0}}, q};
  assign re = {{MW{1'b0}}, r};

  // stage 1: squares and 2qr
  logic [2*MW-1:0] pp1_r;
  logic [DW-1:0]   s1_r, d1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pp1_r <= pe * pe;
      s1_r  <= {1'b0, qe * qe} + {1'b0, re * re};
      d1_r  <= {qe * re, 1'b0};
    end
  end

  // stage 2: |N| clamped to D
  logic [DW-1:0] pp1x, mag2_nxt;
  logic          neg2_nxt;
  assign pp1x = {1'b0, pp1_r};
  always_comb begin
    neg2_nxt = (s1_r < pp1x);
    mag2_nxt = neg2_nxt ? (pp1x - s1_r) : (s1_r - pp1x);
    if (mag2_nxt > d1_r) mag2_nxt = d1_r;
  end

  logic [DW-1:0] mag2_r, d2_r;
  logic          neg2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r <= mag2_nxt;
      d2_r   <= d1_r;
      neg2_r <= neg2_nxt;
    end
  end

  // stage 3: leading one of D
  logic [MSW-1:0] msb3_nxt;
  always_comb begin
    msb3_nxt = '0;
    for (int i = 0; i < DW; i++) begin
      if (d2_r[i]) msb3_nxt = MSW'(i);
    end
  end

  logic [MSW-1:0] msb3_r;
  logic [DW-1:0]  mag3_r, d3_r;
  logic           neg3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      msb3_r <= msb3_nxt;
      mag3_r <= mag2_r;
      d3_r   <= d2_r;
      neg3_r <= neg2_r;
    end
  end

  // stage 4: put the leading one of D at bit NB-1, same shift on |N|
  logic [SHW-1:0] dsh, msh;
  logic [NB-1:0]  dn4_nxt, mn4_nxt;
  assign dsh = {d3_r, {(NB-1){1'b0}}} >> msb3_r;
  assign msh = {mag3_r, {(NB-1){1'b0}}} >> msb3_r;
  always_comb begin
    dn4_nxt = dsh[NB-1:0];
    mn4_nxt = msh[NB-1:0];
    if (mn4_nxt > dn4_nxt) mn4_nxt = dn4_nxt;
  end

  logic [NB-1:0] dn4_r, mn4_r;
  logic          neg4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dn4_r  <= dn4_nxt;
      mn4_r  <= mn4_nxt;
      neg4_r <= neg3_r;
    end
  end

  // stage 5: D^2 and N^2
  logic [2*NB-1:0] dne, mne;
  assign dne = {{NB{1'b0}}, dn4_r};
  assign mne = {{NB{1'b0}}, mn4_r};

  logic [2*NB-1:0] dd5_r, mm5_r;
  logic [NB-1:0]   mn5_r;
  logic            neg5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dd5_r  <= dne * dne;
      mm5_r  <= mne * mne;
      mn5_r  <= mn4_r;
      neg5_r <= neg4_r;
    end
  end

  // stage 6: D^2 - N^2
  logic [2*NB-1:0] rad6_r;
  logic [NB-1:0]   mn6_r;
  logic            neg6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rad6_r <= dd5_r - mm5_r;
      mn6_r  <= mn5_r;
      neg6_r <= neg5_r;
    end
  end

  logic [NB-1:0] y0, x0;
  logic          negf;
  logic signed [ZW-1:0] z;

  taa_isqrt #(.N(2 * NB)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad6_r),
    .root (y0)
  );

  taa_delay #(.W(NB), .D(NB)) u_dly_x (
    .clk (clk),
    .en  (en),
    .d   (mn6_r),
    .q   (x0)
  );

  taa_delay #(.W(1), .D(NB + taa_pkg::CORDIC_STEPS)) u_dly_neg (
    .clk (clk),
    .en  (en),
    .d   (neg6_r),
    .q   (negf)
  );

  taa_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (x0),
    .y_in  (y0),
    .z_out (z)
  );

  // output: clamp to [0,90], mirror for obtuse, round to Q8.8
  logic [PW-1:0] phi, theta;
  logic [PW:0]   rnd;
  logic [taa_pkg::ANGLE_W-1:0] angle_nxt;
  always_comb begin
    if (z < 0) begin
      phi = '0;
    end else if (z > signed'(ZW'(taa_pkg::PHI_MAX))) begin
      phi = taa_pkg::PHI_MAX;
    end else begin
      phi = PW'(z);
    end
    theta = negf ? (taa_pkg::HALF_TURN - phi) : phi;
    rnd   = ({1'b0, theta} + (PW+1)'(128)) >> 8;
    if (rnd > (PW+1)'(taa_pkg::ANGLE_MAX)) begin
      angle_nxt = taa_pkg::ANGLE_MAX;
    end else begin
      angle_nxt = rnd[taa_pkg::ANGLE_W-1:0];
    end
  end

  logic [taa_pkg::ANGLE_W-1:0] angle_r;
  always_ff @(posedge clk) begin
    if (en) angle_r <= angle_nxt;
  end
  assign angle = angle_r;

endmodule
`default_nettype wire

// ===== sv/taa_area.sv =====
`default_nettype none
// Heron area
module taa_area #(
  parameter int SW = taa_pkg::SIDE_WIDTH,
  parameter int FB = taa_pkg::FRACTION_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [SW-1:0]               a,
  input  wire logic [SW-1:0]               b,
  input  wire logic [SW-1:0]               c,
  output logic      [taa_pkg::AREA_W-1:0]  area
);

  localparam int FW = SW + 1;
  localparam int RW = 2 * FW;
  localparam int AW = taa_pkg::AREA_W;
  localparam int XW = RW + AW;

  logic [FW-1:0] ae, be, ce;
  assign ae = {1'b0, a};
  assign be = {1'b0, b};
  assign ce = {1'b0, c};

  logic [FW-1:0] f1_r, f2_r, f3_r, f4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= ae + be + ce;
      f2_r <= be + ce - ae;
      f3_r <= ae + ce - be;
      f4_r <= ae + be - ce;
    end
  end

  logic [2*FW-1:0] p2_r;
  logic [FW-1:0]   f3b_r, f4b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p2_r  <= {{FW{1'b0}}, f1_r} * {{FW{1'b0}}, f2_r};
      f3b_r <= f3_r;
      f4b_r <= f4_r;
    end
  end

  logic [3*FW-1:0] p3_r;
  logic [FW-1:0]   f4c_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p3_r  <= {{FW{1'b0}}, p2_r} * {{(2*FW){1'b0}}, f3b_r};
      f4c_r <= f4b_r;
    end
  end

  // 16 * area^2
  logic [4*FW-1:0] p4_r;
  always_ff @(posedge clk) begin
    if (en) p4_r <= {{FW{1'b0}}, p3_r} * {{(3*FW){1'b0}}, f4c_r};
  end

  logic [RW-1:0] root;
  taa_isqrt #(.N(4 * FW)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (p4_r),
    .root (root)
  );

  logic [XW-1:0] sh;
  assign sh = XW'(root >> (FB + 2));

  logic [AW-1:0] area_r;
  always_ff @(posedge clk) begin
    if (en) begin
      area_r <= (sh > XW'(taa_pkg::AREA_MAX)) ? taa_pkg::AREA_MAX : sh[AW-1:0];
    end
  end
  assign area = area_r;

endmodule
`default_nettype wire

// ===== tb/tb_triangle_area_and_angles_core.sv =====
`default_nettype none
module tb_triangle_area_and_angles_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = taa_pkg::SIDE_WIDTH;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int NUM_RANDOM = 900;

  typedef struct packed {
    taa_pkg::status_t                status;
    logic [taa_pkg::AREA_W-1:0]      area;
    logic [taa_pkg::ANGLE_W-1:0]     angle_a;
    logic [taa_pkg::ANGLE_W-1:0]     angle_b;
    logic [taa_pkg::ANGLE_W-1:0]     angle_c;
  } tri_result_t;

  localparam longint ATAN_TABLE [taa_pkg::CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SW-1:0] in_side_a, in_side_b, in_side_c;
  logic out_valid;
  logic out_ready;
  logic [taa_pkg::STATUS_W-1:0] out_status;
  logic [taa_pkg::AREA_W-1:0] out_area;
  logic [taa_pkg::ANGLE_W-1:0] out_angle_a, out_angle_b, out_angle_c;

  tri_result_t expected_q[$];
  int errors;
  int words_sent;
  int words_checked;
  int status_seen [4];
  bit no_idle;
  int stall_cycles;

  triangle_area_and_angles_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_side_a(in_side_a), .in_side_b(in_side_b), .in_side_c(in_side_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_area(out_area),
    .out_angle_a(out_angle_a), .out_angle_b(out_angle_b), .out_angle_c(out_angle_c)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [taa_pkg::ANGLE_W-1:0] opposite_angle(longint unsigned p,
                                                                 longint unsigned q,
                                                                 longint unsigned r);
    longint unsigned pp, s, d, mag, y0, t;
    bit neg;
    longint x, y, z, xs, ys, phi, theta;
    pp = p * p;
    s = q * q + r * r;
    d = 2 * q * r;
    neg = s < pp;
    mag = neg ? pp - s : s - pp;
    if (mag > d) mag = d;
    while (d >= (64'd1 << taa_pkg::NORM_BITS)) begin
      d = d >> 1;
      mag = mag >> 1;
    end
    while (d < (64'd1 << (taa_pkg::NORM_BITS - 1))) begin
      d = d << 1;
      mag = mag << 1;
    end
    if (mag > d) mag = d;
    y0 = 0;
    for (int i = 31; i >= 0; i--) begin
      t = y0 | (64'd1 << i);
      if (t * t <= d * d - mag * mag) y0 = t;
    end
    x = longint'(mag);
    y = longint'(y0);
    z = 0;
    for (int i = 0; i < taa_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TABLE[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TABLE[i];
      end
    end
    phi = z;
    if (phi < 0) phi = 0;
    if (phi > longint'(taa_pkg::PHI_MAX)) phi = longint'(taa_pkg::PHI_MAX);
    theta = neg ? longint'(taa_pkg::HALF_TURN) - phi : phi;
    theta = (theta + 128) / 256;
    if (theta > longint'(taa_pkg::ANGLE_MAX)) theta = longint'(taa_pkg::ANGLE_MAX);
    return theta[taa_pkg::ANGLE_W-1:0];
  endfunction

  function automatic tri_result_t predict_triangle(logic signed [SW-1:0] sa,
                                                   logic signed [SW-1:0] sb,
                                                   logic signed [SW-1:0] sc);
    tri_result_t res;
    longint a, b, c;
    longint unsigned f1, f2, f3, f4, root, t;
    logic [127:0] prod;
    a = sa;
    b = sb;
    c = sc;
    res = '0;
    if (a == 0 || b == 0 || c == 0) res.status = taa_pkg::ST_ZERO;
    else if (a < 0 || b < 0 || c < 0) res.status = taa_pkg::ST_NEG;
    else if (a + b < c || b + c < a || a + c < b) res.status = taa_pkg::ST_NOTRI;
    else res.status = taa_pkg::ST_OK;
    if (res.status == taa_pkg::ST_OK) begin
      f1 = a + b + c;
      f2 = b + c - a;
      f3 = a + c - b;
      f4 = a + b - c;
      prod = 128'(f1) * 128'(f2) * 128'(f3) * 128'(f4);
      root = 0;
      for (int i = 63; i >= 0; i--) begin
        t = root | (64'd1 << i);
        if (128'(t) * 128'(t) <= prod) root = t;
      end
      root = root >> (taa_pkg::FRACTION_BITS + 2);
      res.area = (root > longint'(taa_pkg::AREA_MAX)) ? taa_pkg::AREA_MAX
                                                       : root[taa_pkg::AREA_W-1:0];
      res.angle_a = opposite_angle(a, b, c);
      res.angle_b = opposite_angle(b, c, a);
      res.angle_c = opposite_angle(c, a, b);
    end
    return res;
  endfunction

  task automatic send_triangle(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                               logic signed [SW-1:0] c);
    int idle;
    idle = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 35) idle++;
    end
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_side_a <= a;
    in_side_b <= b;
    in_side_c <= c;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_q.push_back(predict_triangle(a, b, c));
    words_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // random valid triangle, third side chosen within the inequality bounds, at a random position
  task automatic send_good_triangle(int max_side);
    int a, b, lo, hi;
    a = $urandom_range(1, max_side);
    b = $urandom_range(1, max_side);
    lo = (a > b) ? a - b : b - a;
    if (lo < 1) lo = 1;
    hi = a + b;
    if (hi > max_side) hi = max_side;
    if (lo > hi) lo = hi;
    case ($urandom_range(0, 2))
      0: send_triangle(SW'(a), SW'(b), SW'($urandom_range(lo, hi)));
      1: send_triangle(SW'($urandom_range(lo, hi)), SW'(a), SW'(b));
      default: send_triangle(SW'(b), SW'($urandom_range(lo, hi)), SW'(a));
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    tri_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: status %0d area %0d", $realtime, out_status,
                 out_area);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        words_checked++;
        status_seen[exp_r.status]++;
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status,
                   out_status);
          errors++;
        end
        if (out_area !== exp_r.area) begin
          $display("%0t: area expected %0d actual %0d", $realtime, exp_r.area, out_area);
          errors++;
        end
        if (out_angle_a !== exp_r.angle_a) begin
          $display("%0t: angle_a expected %0d actual %0d", $realtime, exp_r.angle_a,
                   out_angle_a);
          errors++;
        end
        if (out_angle_b !== exp_r.angle_b) begin
          $display("%0t: angle_b expected %0d actual %0d", $realtime, exp_r.angle_b,
                   out_angle_b);
          errors++;
        end
        if (out_angle_c !== exp_r.angle_c) begin
          $display("%0t: angle_c expected %0d actual %0d", $realtime, exp_r.angle_c,
                   out_angle_c);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $realtime,
               expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_triangle(16'sh0300, 16'sh0400, 16'sh0500);
    send_triangle(16'sh0100, 16'sh0100, 16'sh0100);
    send_triangle(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_triangle(16'sh0001, 16'sh0001, 16'sh0001);
    send_triangle(16'sh7FFF, 16'sh7FFF, 16'sh0001);
    send_triangle(16'sh0001, 16'sh7FFF, 16'sh7FFF);
    // zero side wins over a negative one
    send_triangle(16'sh0000, -16'sh0100, 16'sh0100);
    send_triangle(-16'sh8000, 16'sh0100, 16'sh0000);
    send_triangle(16'sh0000, 16'sh0000, 16'sh0000);
    // negative side reported before the inequality test
    send_triangle(-16'sh8000, 16'sh0001, 16'sh7FFF);
    send_triangle(16'sh0100, 16'sh0100, -16'sh0001);
    send_triangle(-16'sh0001, -16'sh0001, -16'sh0001);
    send_triangle(16'sh0100, 16'sh0200, 16'sh0400);
    send_triangle(16'sh7FFF, 16'sh0001, 16'sh0001);
    send_triangle(16'sh0001, 16'sh0002, 16'sh7FFF);
    // degenerate: two sides sum to the third
    send_triangle(16'sh0100, 16'sh0200, 16'sh0300);
    send_triangle(16'sh3FFF, 16'sh4000, 16'sh7FFF);
    send_triangle(16'sh0001, 16'sh0001, 16'sh0002);
    send_triangle(16'sh0500, 16'sh0300, 16'sh0400);
    send_triangle(16'sh0400, 16'sh0500, 16'sh0300);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_good_triangle(32767);
        3, 4: send_good_triangle(512);
        5: send_good_triangle(8);
        6: send_triangle(SW'($urandom_range(0, 3)), SW'($urandom_range(0, 3)),
                         SW'($urandom_range(0, 3)));
        default: send_triangle(SW'($urandom), SW'($urandom), SW'($urandom));
      endcase
    end
  endtask

  task automatic test_drain_pause();
    test_random_mix(20);
    wait_drained();
    test_random_mix(20);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_mix(150);
    no_idle = 1'b0;
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    no_idle = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_side_a = '0;
    in_side_b = '0;
    in_side_c = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random_mix(NUM_RANDOM / 2);
    test_back_to_back();
    test_random_mix(NUM_RANDOM / 2 - 190);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words, checked %0d: ok %0d, zero %0d, negative %0d, no triangle %0d",
             words_sent, words_checked, status_seen[taa_pkg::ST_OK],
             status_seen[taa_pkg::ST_ZERO], status_seen[taa_pkg::ST_NEG],
             status_seen[taa_pkg::ST_NOTRI]);
    $display("Mix of directed edges, valid triangles of all sizes and raw noise, %0d errors",
             errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
